// ===== rtl/umef_pkg.sv =====
// shared types, constants and the header replay function of the endpoint finder
`default_nettype none

package umef_pkg;

    // field and port widths
    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CLASS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SUBCLASS = 1'b1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] MATCH_CLASS_RST    = 8'h01;
    localparam logic [BYTE_W-1:0] MATCH_SUBCLASS_RST = 8'h03;

    // descriptor type codes
    localparam logic [BYTE_W-1:0] KIND_INTERFACE = 8'h04;
    localparam logic [BYTE_W-1:0] KIND_ENDPOINT  = 8'h05;

    // endpoint attribute transfer types
    localparam logic [1:0] XFER_BULK = 2'b10;
    localparam logic [1:0] XFER_INTR = 2'b11;

    // minimum descriptor lengths that carry the checked fields
    localparam logic [BYTE_W-1:0] EP_MIN_LEN    = 8'd4;
    localparam logic [BYTE_W-1:0] IFACE_MIN_LEN = 8'd7;

    // descriptor byte positions
    localparam logic [BYTE_W-1:0] POS_KIND     = 8'd1;
    localparam logic [BYTE_W-1:0] POS_NUMBER   = 8'd2;
    localparam logic [BYTE_W-1:0] POS_ATTR     = 8'd3;
    localparam logic [BYTE_W-1:0] POS_CLASS    = 8'd5;
    localparam logic [BYTE_W-1:0] POS_SUBCLASS = 8'd6;

    // stream offsets of the header bytes
    localparam logic [OFFSET_W-1:0] OFS_LEN   = 16'd0;
    localparam logic [OFFSET_W-1:0] OFS_KIND  = 16'd1;
    localparam logic [OFFSET_W-1:0] OFS_TOT_L = 16'd2;
    localparam logic [OFFSET_W-1:0] OFS_TOT_H = 16'd3;

    // why a search stopped
    typedef enum logic [1:0] {
        STOP_END     = 2'd0,
        STOP_BULK    = 2'd1,
        STOP_ZERO    = 2'd2,
        STOP_OVERRUN = 2'd3
    } t_stop;

    // one result word
    typedef struct packed {
        logic              found;
        logic [BYTE_W-1:0] interface_number;
        logic [BYTE_W-1:0] endpoint_address;
        t_stop             stop_reason;
    } t_result;

    // outcome of the header replay at offset 3
    typedef struct packed {
        logic              stop;
        t_stop             reason;
        logic              len_we;
        logic [BYTE_W-1:0] len;
        logic              kind_we;
        logic [BYTE_W-1:0] kind;
        logic              iface_we;
        logic [BYTE_W-1:0] iface;
        logic              ep_we;
        logic [BYTE_W-1:0] ep;
        logic [BYTE_W-1:0] pos;
    } t_head;

    // walk the descriptors that start in the first four bytes
    function automatic t_head head_replay(
        input logic [BYTE_W-1:0]   b0,
        input logic [BYTE_W-1:0]   b1,
        input logic [BYTE_W-1:0]   b2,
        input logic [BYTE_W-1:0]   b3,
        input logic [OFFSET_W-1:0] total
    );
        t_head                   h;
        logic [3:0][BYTE_W-1:0]  bytes;
        logic [2:0]              s;
        logic                    live;
        logic [BYTE_W-1:0]       len;
        logic [OFFSET_W:0]       tot;
        h        = '0;
        h.reason = STOP_END;
        bytes    = {b3, b2, b1, b0};
        s        = 3'd0;
        live     = 1'b1;
        len      = '0;
        tot      = {1'b0, total};
        for (int i = 0; i < 5; i++) begin
            if (live) begin
                len = bytes[s[1:0]];
                if ({14'd0, s} + 17'd2 > tot) begin
                    h.stop   = 1'b1;
                    h.reason = STOP_END;
                    live     = 1'b0;
                end else if (s[2]) begin
                    h.pos = '0;
                    live  = 1'b0;
                end else if (len == '0) begin
                    h.stop   = 1'b1;
                    h.reason = STOP_ZERO;
                    live     = 1'b0;
                end else if ({14'd0, s} + {9'd0, len} > tot) begin
                    h.stop   = 1'b1;
                    h.reason = STOP_OVERRUN;
                    live     = 1'b0;
                end else if ({6'd0, s} + {1'b0, len} <= 9'd4) begin
                    s = s + len[2:0];
                end else begin
                    // descriptor runs past the header: absorb what is already here
                    h.len_we  = 1'b1;
                    h.len     = len;
                    h.kind_we = 1'b1;
                    h.pos     = 8'd4 - {5'd0, s};
                    case (s[1:0])
                        2'd0: begin
                            h.kind = b1;
                            if (b1 == KIND_INTERFACE) begin
                                h.iface_we = 1'b1;
                                h.iface    = b2;
                            end else if (b1 == KIND_ENDPOINT) begin
                                h.ep_we = 1'b1;
                                h.ep    = b2;
                            end
                        end
                        2'd1: begin
                            h.kind = b2;
                            if (b2 == KIND_INTERFACE) begin
                                h.iface_we = 1'b1;
                                h.iface    = b3;
                            end else if (b2 == KIND_ENDPOINT) begin
                                h.ep_we = 1'b1;
                                h.ep    = b3;
                            end
                        end
                        2'd2: h.kind = b3;
                        default: h.kind = '0;
                    endcase
                    live = 1'b0;
                end
            end
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/umef_in_if.sv =====
// input channel: one descriptor byte per word
`default_nettype none

interface umef_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source(output valid, output data_byte, output first_byte, input ready);
    modport sink(input valid, input data_byte, input first_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/umef_out_if.sv =====
// output channel: one search result per word
`default_nettype none

interface umef_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] interface_number;
    logic [7:0] endpoint_address;
    logic [1:0] stop_reason;

    modport source(output valid, output found, output interface_number,
                   output endpoint_address, output stop_reason, input ready);
    modport sink(input valid, input found, input interface_number,
                 input endpoint_address, input stop_reason, output ready);
endinterface

`default_nettype wire

// ===== rtl/umef_walker.sv =====
// descriptor walk state and the per-byte update logic
`default_nettype none

module umef_walker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [umef_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                           i_first_byte,
    input  logic [umef_pkg::BYTE_W-1:0]    i_match_class,
    input  logic [umef_pkg::BYTE_W-1:0]    i_match_subclass,
    output logic                           o_hit,
    output umef_pkg::t_result              o_result
);
    import umef_pkg::*;

    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [OFFSET_W-1:0] r_total, n_total;
    logic [BYTE_W-1:0]   r_pos, n_pos;
    logic [BYTE_W-1:0]   r_len, n_len;
    logic [BYTE_W-1:0]   r_kind, n_kind;
    logic                r_match, n_match;
    logic [BYTE_W-1:0]   r_class_seen, n_class_seen;
    logic [BYTE_W-1:0]   r_iface, n_iface;
    logic [BYTE_W-1:0]   r_ep, n_ep;
    logic                r_fb_valid, n_fb_valid;
    logic [BYTE_W-1:0]   r_fb_iface, n_fb_iface;
    logic [BYTE_W-1:0]   r_fb_ep, n_fb_ep;
    logic                r_done, n_done;

    // view of the state after a possible restart
    logic [OFFSET_W-1:0] c_offset, c_total;
    logic [BYTE_W-1:0]   c_pos, c_len, c_kind, c_class_seen, c_iface, c_ep;
    logic                c_match, c_fb_valid;

    logic                active;
    logic                stop;
    t_stop               reason;
    t_head               head;
    logic [OFFSET_W-1:0] tot_full;
    logic [BYTE_W-1:0]   pos_inc;
    logic [BYTE_W-1:0]   len_now;

    // restart clears the search before the byte is handled
    always_comb begin
        c_offset     = i_first_byte ? '0 : r_offset;
        c_total      = i_first_byte ? '0 : r_total;
        c_pos        = i_first_byte ? '0 : r_pos;
        c_len        = i_first_byte ? '0 : r_len;
        c_kind       = i_first_byte ? '0 : r_kind;
        c_match      = i_first_byte ? 1'b0 : r_match;
        c_class_seen = i_first_byte ? '0 : r_class_seen;
        c_iface      = i_first_byte ? '0 : r_iface;
        c_ep         = i_first_byte ? '0 : r_ep;
        c_fb_valid   = i_first_byte ? 1'b0 : r_fb_valid;
        active       = i_step && (i_first_byte || !r_done);
        tot_full     = {i_data_byte, c_total[BYTE_W-1:0]};
        head         = head_replay(c_len, c_kind, c_total[BYTE_W-1:0], i_data_byte, tot_full);
        pos_inc      = c_pos + 8'd1;
        len_now      = (c_pos == '0) ? i_data_byte : c_len;
    end

    // per-byte state update
    always_comb begin
        n_offset     = r_offset;
        n_total      = r_total;
        n_pos        = r_pos;
        n_len        = r_len;
        n_kind       = r_kind;
        n_match      = r_match;
        n_class_seen = r_class_seen;
        n_iface      = r_iface;
        n_ep         = r_ep;
        n_fb_valid   = r_fb_valid;
        n_fb_iface   = r_fb_iface;
        n_fb_ep      = r_fb_ep;
        n_done       = r_done;
        stop         = 1'b0;
        reason       = STOP_END;

        if (i_step && i_first_byte) begin
            n_offset     = '0;
            n_total      = '0;
            n_pos        = '0;
            n_len        = '0;
            n_kind       = '0;
            n_match      = 1'b0;
            n_class_seen = '0;
            n_iface      = '0;
            n_ep         = '0;
            n_fb_valid   = 1'b0;
            n_fb_iface   = '0;
            n_fb_ep      = '0;
            n_done       = 1'b0;
        end

        if (active) begin
            n_offset = c_offset + 16'd1;
            if (c_offset == OFS_LEN) begin
                n_len = i_data_byte;
            end else if (c_offset == OFS_KIND) begin
                n_kind = i_data_byte;
            end else if (c_offset == OFS_TOT_L) begin
                n_total = {8'd0, i_data_byte};
            end else if (c_offset == OFS_TOT_H) begin
                // total length complete: replay the header descriptors
                n_total = tot_full;
                stop    = head.stop;
                reason  = head.reason;
                if (!head.stop) n_pos = head.pos;
                if (head.len_we) n_len = head.len;
                if (head.kind_we) n_kind = head.kind;
                if (head.iface_we) n_iface = head.iface;
                if (head.ep_we) n_ep = head.ep;
            end else begin
                if (c_pos == '0) begin
                    // length byte of a new descriptor
                    n_len  = i_data_byte;
                    n_kind = '0;
                    if (i_data_byte == '0) begin
                        stop   = 1'b1;
                        reason = STOP_ZERO;
                    end else if ({1'b0, c_offset} + {9'd0, i_data_byte} >
                                 {1'b0, c_total}) begin
                        stop   = 1'b1;
                        reason = STOP_OVERRUN;
                    end
                end else if (c_pos == POS_KIND) begin
                    n_kind = i_data_byte;
                    if (i_data_byte == KIND_INTERFACE) n_match = 1'b0;
                end else if (c_pos == POS_NUMBER) begin
                    if (c_kind == KIND_INTERFACE) n_iface = i_data_byte;
                    else if (c_kind == KIND_ENDPOINT) n_ep = i_data_byte;
                end else if (c_pos == POS_ATTR) begin
                    // OUT endpoint of a matching interface
                    if (c_kind == KIND_ENDPOINT && c_len >= EP_MIN_LEN && c_match &&
                        !c_ep[BYTE_W-1]) begin
                        if (i_data_byte[1:0] == XFER_BULK) begin
                            stop   = 1'b1;
                            reason = STOP_BULK;
                        end else if (i_data_byte[1:0] == XFER_INTR && !c_fb_valid) begin
                            n_fb_valid = 1'b1;
                            n_fb_iface = c_iface;
                            n_fb_ep    = c_ep;
                        end
                    end
                end else if (c_pos == POS_CLASS) begin
                    if (c_kind == KIND_INTERFACE) n_class_seen = i_data_byte;
                end else if (c_pos == POS_SUBCLASS) begin
                    if (c_kind == KIND_INTERFACE && c_len >= IFACE_MIN_LEN &&
                        c_class_seen == i_match_class && i_data_byte == i_match_subclass)
                        n_match = 1'b1;
                end

                // advance within the descriptor, end test at its last byte
                if (!stop) begin
                    if (pos_inc >= len_now) begin
                        n_pos = '0;
                        if ({1'b0, c_offset} + 17'd3 > {1'b0, c_total}) begin
                            stop   = 1'b1;
                            reason = STOP_END;
                        end
                    end else begin
                        n_pos = pos_inc;
                    end
                end
            end
            if (stop) n_done = 1'b1;
        end
    end

    // result of a stopping byte
    always_comb begin
        o_hit                = active && stop;
        o_result.stop_reason = reason;
        if (reason == STOP_BULK) begin
            o_result.found            = 1'b1;
            o_result.interface_number = n_iface;
            o_result.endpoint_address = n_ep;
        end else if (n_fb_valid) begin
            o_result.found            = 1'b1;
            o_result.interface_number = n_fb_iface;
            o_result.endpoint_address = n_fb_ep;
        end else begin
            o_result.found            = 1'b0;
            o_result.interface_number = '0;
            o_result.endpoint_address = '0;
        end
    end

    // walk state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= '0;
            r_total      <= '0;
            r_pos        <= '0;
            r_len        <= '0;
            r_kind       <= '0;
            r_match      <= 1'b0;
            r_class_seen <= '0;
            r_iface      <= '0;
            r_ep         <= '0;
            r_fb_valid   <= 1'b0;
            r_fb_iface   <= '0;
            r_fb_ep      <= '0;
            r_done       <= 1'b1;
        end else begin
            r_offset     <= n_offset;
            r_total      <= n_total;
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_kind       <= n_kind;
            r_match      <= n_match;
            r_class_seen <= n_class_seen;
            r_iface      <= n_iface;
            r_ep         <= n_ep;
            r_fb_valid   <= n_fb_valid;
            r_fb_iface   <= n_fb_iface;
            r_fb_ep      <= n_fb_ep;
            r_done       <= n_done;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/usb_midi_out_endpoint_finder_unit.sv =====
// top level of the USB MIDI OUT endpoint finder
//
//  channel   dir  modport  word
//  i_in      in   sink     data_byte, first_byte
//  o_out     out  source   found, interface_number, endpoint_address, stop_reason
//  i_cfg_*   in   -        write enable, register index, 8-bit data
//
//  one byte per cycle unless a held result stalls: a byte waits in the input register,
//  then the walker updates its state and a stopping byte loads the result register
//  the result word is valid from the edge at which its byte leaves the input register
//  synchronous active-low reset; the block comes out idle until a first byte
//  a result held by a stalled sink stalls the walker; the input register still takes one byte
`default_nettype none

module usb_midi_out_endpoint_finder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    umef_in_if.sink                             i_in,
    umef_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [umef_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [umef_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import umef_pkg::*;

    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;
    logic              r_out_valid, n_out_valid;
    t_result           r_out;
    logic [BYTE_W-1:0] r_match_class, r_match_subclass;

    logic              consume;
    logic              accept;
    logic              hit;
    t_result           result;

    // handshake control
    assign consume     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || consume;
    assign accept      = i_in.valid && i_in.ready;
    assign n_in_valid  = accept || (r_in_valid && !consume);
    assign n_out_valid = (consume && hit) || (r_out_valid && !o_out.ready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_class    <= MATCH_CLASS_RST;
            r_match_subclass <= MATCH_SUBCLASS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATCH_CLASS:    r_match_class    <= i_cfg_data;
                CFG_MATCH_SUBCLASS: r_match_subclass <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_valid <= 1'b0;
        else          r_in_valid <= n_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte  <= i_in.data_byte;
            r_in_first <= i_in.first_byte;
        end
    end

    // descriptor walker
    umef_walker u_walker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (consume),
        .i_data_byte      (r_in_byte),
        .i_first_byte     (r_in_first),
        .i_match_class    (r_match_class),
        .i_match_subclass (r_match_subclass),
        .o_hit            (hit),
        .o_result         (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else          r_out_valid <= n_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (consume && hit) r_out <= result;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.found            = r_out.found;
    assign o_out.interface_number = r_out.interface_number;
    assign o_out.endpoint_address = r_out.endpoint_address;
    assign o_out.stop_reason      = r_out.stop_reason;

endmodule

`default_nettype wire

// ===== bench/umef_checker.sv =====
// checker for the endpoint finder: predicts each search result and compares it on the output channel
`timescale 1ns / 1ps

module umef_checker
    import umef_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    umef_in_if                    in_ch,
    umef_out_if                   out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_mismatches
);

    // match registers as the block should hold them
    logic [BYTE_W-1:0]   want_cls;
    logic [BYTE_W-1:0]   want_sub;

    // descriptor walk state
    logic [OFFSET_W-1:0] pos_in_stream;
    logic [OFFSET_W-1:0] total_len;
    logic [BYTE_W-1:0]   desc_pos;
    logic [BYTE_W-1:0]   desc_len;
    logic [BYTE_W-1:0]   desc_type;
    logic [BYTE_W-1:0]   class_seen;
    logic [BYTE_W-1:0]   iface_num;
    logic [BYTE_W-1:0]   ep_addr;
    logic [BYTE_W-1:0]   fb_iface;
    logic [BYTE_W-1:0]   fb_ep;
    bit                  iface_hit;
    bit                  fb_valid;
    bit                  walk_idle;

    t_result             search_results[$];
    int                  misses = 0;

    // restart the walk at a first byte
    function automatic void clear_walk();
        pos_in_stream = '0;
        total_len     = '0;
        desc_pos      = '0;
        desc_len      = '0;
        desc_type     = '0;
        class_seen    = '0;
        iface_num     = '0;
        ep_addr       = '0;
        fb_iface      = '0;
        fb_ep         = '0;
        iface_hit     = 1'b0;
        fb_valid      = 1'b0;
    endfunction

    // build the result of a stopped search
    function automatic t_result conclude(t_stop why);
        t_result r;
        r = '0;
        if (why == STOP_BULK) begin
            r.found            = 1'b1;
            r.interface_number = iface_num;
            r.endpoint_address = ep_addr;
        end else if (fb_valid) begin
            r.found            = 1'b1;
            r.interface_number = fb_iface;
            r.endpoint_address = fb_ep;
        end
        r.stop_reason = why;
        walk_idle     = 1'b1;
        return r;
    endfunction

    // one byte inside a descriptor; returns 1 on a bulk out endpoint of a matching interface
    function automatic bit take_field(logic [BYTE_W-1:0] p, logic [BYTE_W-1:0] b);
        bit bulk;
        bulk = 1'b0;
        case (p)
            POS_KIND: begin
                desc_type = b;
                if (b == KIND_INTERFACE) iface_hit = 1'b0;
            end
            POS_NUMBER: begin
                if (desc_type == KIND_INTERFACE) iface_num = b;
                else if (desc_type == KIND_ENDPOINT) ep_addr = b;
            end
            POS_ATTR: begin
                if (desc_type == KIND_ENDPOINT && desc_len >= EP_MIN_LEN && iface_hit &&
                    !ep_addr[7]) begin
                    if (b[1:0] == XFER_BULK) begin
                        bulk = 1'b1;
                    end else if (b[1:0] == XFER_INTR && !fb_valid) begin
                        fb_valid = 1'b1;
                        fb_iface = iface_num;
                        fb_ep    = ep_addr;
                    end
                end
            end
            POS_CLASS: begin
                if (desc_type == KIND_INTERFACE) class_seen = b;
            end
            POS_SUBCLASS: begin
                if (desc_type == KIND_INTERFACE && desc_len >= IFACE_MIN_LEN &&
                    class_seen == want_cls && b == want_sub)
                    iface_hit = 1'b1;
            end
            default: ;
        endcase
        return bulk;
    endfunction

    // at offset 3 the descriptors that begin in the first four bytes are walked
    function automatic bit check_head(logic [BYTE_W-1:0] b3, output t_result r);
        logic [BYTE_W-1:0] hb [4];
        int                total;
        int                s;
        int                len;
        bit                done;
        bit                stop;
        hb[0] = desc_len;
        hb[1] = desc_type;
        hb[2] = total_len[7:0];
        hb[3] = b3;
        total = total_len;
        s     = 0;
        done  = 1'b0;
        stop  = 1'b0;
        r     = '0;
        while (!done) begin
            if (s + 2 > total) begin
                r    = conclude(STOP_END);
                stop = 1'b1;
                done = 1'b1;
            end else if (s >= 4) begin
                desc_pos = '0;
                done     = 1'b1;
            end else begin
                len = hb[s];
                if (len == 0) begin
                    r    = conclude(STOP_ZERO);
                    stop = 1'b1;
                    done = 1'b1;
                end else if (s + len > total) begin
                    r    = conclude(STOP_OVERRUN);
                    stop = 1'b1;
                    done = 1'b1;
                end else if (s + len <= 4) begin
                    s = s + len;
                end else begin
                    // descriptor runs past the header
                    desc_len  = 8'(len);
                    desc_type = '0;
                    for (int p = 1; s + p <= 3; p++) void'(take_field(8'(p), hb[s+p]));
                    desc_pos = 8'(4 - s);
                    done     = 1'b1;
                end
            end
        end
        return stop;
    endfunction

    // step past a body byte and test for the end of the stream
    function automatic bit advance_pos(int o, output t_result r);
        bit stop;
        stop     = 1'b0;
        r        = '0;
        desc_pos = desc_pos + 8'd1;
        if (desc_pos >= desc_len) begin
            desc_pos = '0;
            if (o + 3 > total_len) begin
                r    = conclude(STOP_END);
                stop = 1'b1;
            end
        end
        return stop;
    endfunction

    // one accepted input word; returns 1 when a search result is due
    function automatic bit walk_byte(logic [BYTE_W-1:0] b, bit first, output t_result r);
        int o;
        bit stop;
        stop = 1'b0;
        r    = '0;
        if (first) begin
            clear_walk();
            walk_idle = 1'b0;
        end
        if (!walk_idle) begin
            o             = pos_in_stream;
            pos_in_stream = pos_in_stream + 16'd1;
            if (o == OFS_LEN) begin
                desc_len = b;
            end else if (o == OFS_KIND) begin
                desc_type = b;
            end else if (o == OFS_TOT_L) begin
                total_len = {8'h00, b};
            end else if (o == OFS_TOT_H) begin
                total_len[15:8] = b;
                stop = check_head(b, r);
            end else if (desc_pos == '0) begin
                desc_len  = b;
                desc_type = '0;
                if (b == '0) begin
                    r    = conclude(STOP_ZERO);
                    stop = 1'b1;
                end else if (o + b > total_len) begin
                    r    = conclude(STOP_OVERRUN);
                    stop = 1'b1;
                end else begin
                    stop = advance_pos(o, r);
                end
            end else if (take_field(desc_pos, b)) begin
                r    = conclude(STOP_BULK);
                stop = 1'b1;
            end else begin
                stop = advance_pos(o, r);
            end
        end
        return stop;
    endfunction

    // compare result words, then predict from input words and track register writes
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            want_cls  = MATCH_CLASS_RST;
            want_sub  = MATCH_SUBCLASS_RST;
            clear_walk();
            walk_idle = 1'b1;
            search_results.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.found            = out_ch.found;
                got.interface_number = out_ch.interface_number;
                got.endpoint_address = out_ch.endpoint_address;
                got.stop_reason      = t_stop'(out_ch.stop_reason);
                if (search_results.size() == 0) begin
                    if (misses < 10)
                        $display("umef_checker: unexpected word found=%0d if=%02h ep=%02h stop=%0d",
                                 got.found, got.interface_number, got.endpoint_address,
                                 got.stop_reason);
                    misses++;
                end else begin
                    want = search_results.pop_front();
                    if (got.found !== want.found ||
                        got.interface_number !== want.interface_number ||
                        got.endpoint_address !== want.endpoint_address ||
                        got.stop_reason !== want.stop_reason) begin
                        if (misses < 10)
                            $display("umef_checker: mismatch exp %0d/%02h/%02h/%0d got %0d/%02h/%02h/%0d",
                                     want.found, want.interface_number, want.endpoint_address,
                                     want.stop_reason, got.found, got.interface_number,
                                     got.endpoint_address, got.stop_reason);
                        misses++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (walk_byte(in_ch.data_byte, in_ch.first_byte, pred))
                    search_results.push_back(pred);
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MATCH_CLASS) want_cls = i_cfg_data;
                else want_sub = i_cfg_data;
            end
        end
        o_pending    <= search_results.size();
        o_mismatches <= misses;
    end

endmodule

// ===== bench/tb_top.sv =====
// testbench top: clock, reset, descriptor stream stimulus, result sink and verdict
`timescale 1ns / 1ps

module tb_top;
    import umef_pkg::*;

    localparam logic [7:0] KIND_CONFIG    = 8'h02;
    localparam logic [7:0] KIND_CS_IFACE  = 8'h24;
    localparam logic [7:0] KIND_CS_EP     = 8'h25;
    localparam logic [7:0] KIND_ASSOC     = 8'h0B;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         PHASES         = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    umef_in_if  in_ch ();
    umef_out_if out_ch ();

    int         pending;
    int         mismatches;
    int         sent_bytes  = 0;
    int         quiet       = 0;
    bit         tx_calm     = 1'b0;
    bit         rx_calm     = 1'b0;
    logic [7:0] m_cls;
    logic [7:0] m_sub;
    logic [7:0] desc_bytes[$];

    usb_midi_out_endpoint_finder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    umef_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // end the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result sink with a random stall before each word
    initial begin
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                hold = rx_calm ? 0 : $urandom_range(0, 9);
            end else if (hold > 0) begin
                hold--;
            end
            out_ch.ready <= (hold == 0) && i_rst_n;
        end
    end

    // send one byte word after a random gap
    task automatic push_byte(input logic [7:0] b, input bit first);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.first_byte <= first;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_bytes++;
    endtask

    // stop sending and wait until every result is in and the block is quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // write both match registers
    task automatic set_match(input logic [7:0] cls, input logic [7:0] sub);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MATCH_CLASS;
        i_cfg_data <= cls;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MATCH_SUBCLASS;
        i_cfg_data <= sub;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        m_cls = cls;
        m_sub = sub;
    endtask

    // append one descriptor; unnamed bytes are random
    task automatic put_desc(input int len, input logic [7:0] kind, input logic [7:0] at2,
                            input logic [7:0] at3, input logic [7:0] at5,
                            input logic [7:0] at6);
        desc_bytes.push_back(8'(len));
        if (len > 1) desc_bytes.push_back(kind);
        for (int k = 2; k < len; k++)
            desc_bytes.push_back(k == 2 ? at2 : k == 3 ? at3 : k == 5 ? at5 :
                                 k == 6 ? at6 : 8'($urandom));
    endtask

    // interface descriptor, mostly aimed at the match registers
    task automatic add_iface();
        logic [7:0] c;
        logic [7:0] sc;
        int         len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 6) : 9;
        case ($urandom_range(0, 5))
            0, 1, 2: begin c = m_cls; sc = m_sub; end
            3:       begin c = m_cls; sc = m_sub ^ (8'd1 << $urandom_range(0, 7)); end
            4:       begin c = m_cls ^ (8'd1 << $urandom_range(0, 7)); sc = m_sub; end
            default: begin c = 8'($urandom); sc = 8'($urandom); end
        endcase
        put_desc(len, KIND_INTERFACE, 8'($urandom), 8'($urandom), c, sc);
    endtask

    // endpoint descriptor with bulk and interrupt types favored
    task automatic add_endpoint();
        int         len;
        logic [7:0] addr;
        logic [7:0] attr;
        case ($urandom_range(0, 9))
            0:       len = $urandom_range(2, 3);
            1:       len = $urandom_range(4, 6);
            2:       len = 9;
            default: len = 7;
        endcase
        addr = 8'($urandom);
        if ($urandom_range(0, 2) != 0) addr[7] = 1'b0;
        attr = 8'($urandom);
        case ($urandom_range(0, 5))
            0, 1:    attr[1:0] = XFER_BULK;
            2, 3:    attr[1:0] = XFER_INTR;
            default: ;
        endcase
        put_desc(len, KIND_ENDPOINT, addr, attr, 8'($urandom), 8'($urandom));
    endtask

    // descriptor of some other type
    task automatic add_other();
        logic [7:0] kind;
        case ($urandom_range(0, 3))
            0:       kind = KIND_CS_IFACE;
            1:       kind = KIND_CS_EP;
            2:       kind = KIND_ASSOC;
            default: kind = 8'($urandom);
        endcase
        put_desc($urandom_range(2, 10), kind, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    endtask

    // one configuration descriptor, mostly well formed, sometimes broken
    task automatic build_stream();
        int          hl;
        logic [15:0] tot;
        desc_bytes.delete();
        hl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : 9;
        put_desc(hl, KIND_CONFIG, 8'h00, 8'h00, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 40)) desc_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 3) == 0) add_other();
                add_iface();
                if ($urandom_range(0, 1) == 0) add_other();
                repeat ($urandom_range(0, 3)) add_endpoint();
                // zero length descriptor
                if ($urandom_range(0, 15) == 0) desc_bytes.push_back(8'h00);
            end
        end
        while (desc_bytes.size() < 4) desc_bytes.push_back(8'($urandom));
        case ($urandom_range(0, 9))
            7:       tot = 16'($urandom_range(0, desc_bytes.size() - 1));
            8:       tot = 16'(desc_bytes.size() + $urandom_range(1, 12));
            9:       tot = 16'($urandom);
            default: tot = 16'(desc_bytes.size());
        endcase
        desc_bytes[2] = tot[7:0];
        desc_bytes[3] = tot[15:8];
    endtask

    // send the first words of the built stream
    task automatic send_stream(input int upto);
        for (int k = 0; k < upto; k++) push_byte(desc_bytes[k], k == 0);
    endtask

    // stimulus
    initial begin
        int phase_bytes;
        int cut;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_MATCH_CLASS;
        i_cfg_data       <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= '0;
        in_ch.first_byte <= 1'b0;
        m_cls = MATCH_CLASS_RST;
        m_sub = MATCH_SUBCLASS_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bulk out endpoint of a matching interface
        desc_bytes = '{8'd4, KIND_CONFIG, 8'd15, 8'd0,
                       8'd7, KIND_INTERFACE, 8'hFF, 8'h00, 8'h01, MATCH_CLASS_RST,
                       MATCH_SUBCLASS_RST,
                       8'd4, KIND_ENDPOINT, 8'h7F, {6'h00, XFER_BULK}};
        send_stream(desc_bytes.size());
        // total length zero ends at once
        desc_bytes = '{8'd9, KIND_CONFIG, 8'h00, 8'h00};
        send_stream(desc_bytes.size());
        // zero length header
        desc_bytes = '{8'h00, KIND_CONFIG, 8'hFF, 8'hFF};
        send_stream(desc_bytes.size());
        // header longer than the total length
        desc_bytes = '{8'd9, KIND_CONFIG, 8'd5, 8'd0};
        send_stream(desc_bytes.size());
        // byte while idle is ignored
        push_byte(8'hFF, 1'b0);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       set_match(8'h00, 8'h00);
                1:       set_match(8'hFF, 8'hFF);
                2:       set_match(MATCH_CLASS_RST, MATCH_SUBCLASS_RST);
                3:       set_match(8'hFF, 8'h00);
                default: set_match(8'($urandom), 8'($urandom));
            endcase
            phase_bytes = sent_bytes;
            while (sent_bytes - phase_bytes < 190) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
                // stray bytes between streams
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
                build_stream();
                cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, desc_bytes.size())
                                                   : desc_bytes.size();
                send_stream(cut);
                // hold off until every pending result is in
                if ($urandom_range(0, 9) == 0) settle();
            end
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
